// ----- rtl/i2cme_pkg.sv -----
`default_nettype none

package i2cme_pkg;

    localparam int KIND_W      = 3;
    localparam int BYTE_W      = 8;
    localparam int BITCNT_W    = 4;
    localparam int S_TDATA_W   = 16;
    localparam int S_TUSER_W   = 3;
    localparam int M_TDATA_W   = 16;

    localparam logic [BYTE_W-1:0]   ACK_TIMEOUT_RST = 8'd250;
    localparam logic [BITCNT_W-1:0] BITS_PER_BYTE   = 4'd8;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK  = 3'd0,
        KIND_START = 3'd1,
        KIND_STOP  = 3'd2,
        KIND_WRITE = 3'd3,
        KIND_READ  = 3'd4,
        KIND_WACK  = 3'd5,
        KIND_ACK   = 3'd6,
        KIND_NACK  = 3'd7
    } t_kind;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_ST1     = 4'd1,
        PH_ST2     = 4'd2,
        PH_SP1     = 4'd3,
        PH_SP2     = 4'd4,
        PH_WR_HI   = 4'd5,
        PH_WR_LO   = 4'd6,
        PH_RD_HI   = 4'd7,
        PH_RD_LO   = 4'd8,
        PH_AK_HI   = 4'd9,
        PH_AK_LO   = 4'd10,
        PH_WA_HI   = 4'd11,
        PH_WA_POLL = 4'd12,
        PH_FS1     = 4'd13,
        PH_FS2     = 4'd14
    } t_phase;

    typedef struct packed {
        logic              rejected;
        logic [BYTE_W-1:0] read_data;
        logic              ack_failed;
        logic              done_res;
        logic              busy_res;
        logic              sda_drive;
        logic              sda_out;
        logic              scl;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/i2c_master_bit_engine.sv -----
`default_nettype none

// Channel  Dir  Handshake                      Payload
// s_axis   in   s_axis_tvalid/s_axis_tready    tdata: tx_byte, send_ack, sda_in; tuser: kind
// m_axis   out  m_axis_tvalid/m_axis_tready    tdata: scl .. rejected (see port comment)
// cfg      in   i_cfg_valid/o_cfg_ready        i_cfg_data: ack_timeout
//
// One item per clock; its result appears in the output register in the cycle after
// acceptance. The slot sequencer and the result logic sit between the input port and
// that register, so the rate is set only by m_axis_tready.
// A full output register that is not being taken stalls s_axis; reset is synchronous
// and active low, and leaves the bus released (SCL and SDA high) and the engine idle.

module i2c_master_bit_engine (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,

    input  wire logic                             s_axis_tvalid,
    output      logic                             s_axis_tready,
    // [7:0] tx_byte, [8] send_ack, [9] sda_in, [15:10] zero
    input  wire logic [i2cme_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // [2:0] kind
    input  wire logic [i2cme_pkg::S_TUSER_W-1:0]  s_axis_tuser,

    output      logic                             m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // [0] scl, [1] sda_out, [2] sda_drive, [3] busy_res, [4] done_res,
    // [5] ack_failed, [13:6] read_data, [14] rejected, [15] zero
    output      logic [i2cme_pkg::M_TDATA_W-1:0]  m_axis_tdata,

    input  wire logic                             i_cfg_valid,
    output      logic                             o_cfg_ready,
    input  wire logic [i2cme_pkg::BYTE_W-1:0]     i_cfg_data
);

    i2cme_pkg::t_phase                       r_phase, n_phase;
    logic [i2cme_pkg::BITCNT_W-1:0]          r_bit_count, n_bit_count;
    logic [i2cme_pkg::BYTE_W-1:0]            r_shift, n_shift;
    logic [i2cme_pkg::BYTE_W-1:0]            r_poll, n_poll;
    logic                                    r_scl, n_scl;
    logic                                    r_sda, n_sda;
    logic                                    r_sda_en, n_sda_en;
    logic                                    r_ack_choice, n_ack_choice;
    logic [i2cme_pkg::BYTE_W-1:0]            r_ack_timeout;
    i2cme_pkg::t_result                      r_res, n_res;
    logic                                    r_out_valid;

    logic                                    w_accept;
    logic                                    w_idle;
    i2cme_pkg::t_kind                        w_kind;
    logic [i2cme_pkg::BYTE_W-1:0]            w_tx_byte;
    logic                                    w_send_ack;
    logic                                    w_sda_in;
    logic [i2cme_pkg::BITCNT_W-1:0]          w_bit_inc;
    logic [i2cme_pkg::BYTE_W-1:0]            w_shift_up;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign w_kind     = i2cme_pkg::t_kind'(s_axis_tuser[i2cme_pkg::KIND_W-1:0]);
    assign w_tx_byte  = s_axis_tdata[7:0];
    assign w_send_ack = s_axis_tdata[8];
    assign w_sda_in   = s_axis_tdata[9];

    // a phase code outside the sequence counts as idle
    assign w_idle     = (r_phase == i2cme_pkg::PH_IDLE) ||
                        (4'(r_phase) > 4'(i2cme_pkg::PH_FS2));
    assign w_bit_inc  = r_bit_count + 4'd1;
    assign w_shift_up = {r_shift[i2cme_pkg::BYTE_W-2:0], 1'b0};

    // next state
    always_comb begin
        n_phase      = r_phase;
        n_bit_count  = r_bit_count;
        n_shift      = r_shift;
        n_poll       = r_poll;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_sda_en     = r_sda_en;
        n_ack_choice = r_ack_choice;
        if (!w_idle) begin
            n_phase = r_phase;
        end else begin
            n_phase = i2cme_pkg::PH_IDLE;
        end
        if (w_kind != i2cme_pkg::KIND_TICK) begin
            if (w_idle) begin
                case (w_kind)
                    i2cme_pkg::KIND_START: begin
                        n_sda_en = 1'b1; n_sda = 1'b1; n_scl = 1'b1;
                        n_phase  = i2cme_pkg::PH_ST1;
                    end
                    i2cme_pkg::KIND_STOP: begin
                        n_sda_en = 1'b1; n_sda = 1'b0; n_scl = 1'b0;
                        n_phase  = i2cme_pkg::PH_SP1;
                    end
                    i2cme_pkg::KIND_WRITE: begin
                        n_sda_en    = 1'b1; n_scl = 1'b0;
                        n_shift     = w_tx_byte;
                        n_bit_count = '0;
                        n_sda       = w_tx_byte[i2cme_pkg::BYTE_W-1];
                        n_phase     = i2cme_pkg::PH_WR_HI;
                    end
                    i2cme_pkg::KIND_READ: begin
                        n_sda_en     = 1'b0; n_sda = 1'b1; n_scl = 1'b0;
                        n_shift      = '0;
                        n_bit_count  = '0;
                        n_ack_choice = w_send_ack;
                        n_phase      = i2cme_pkg::PH_RD_HI;
                    end
                    i2cme_pkg::KIND_WACK: begin
                        n_sda_en = 1'b0; n_sda = 1'b1; n_scl = 1'b0;
                        n_poll   = '0;
                        n_phase  = i2cme_pkg::PH_WA_HI;
                    end
                    default: begin
                        n_sda_en    = 1'b1; n_scl = 1'b0;
                        n_sda       = (w_kind == i2cme_pkg::KIND_NACK);
                        n_bit_count = '0;
                        n_phase     = i2cme_pkg::PH_AK_HI;
                    end
                endcase
            end
        end else begin
            unique case (r_phase)
                i2cme_pkg::PH_ST1: begin
                    n_sda = 1'b0; n_phase = i2cme_pkg::PH_ST2;
                end
                i2cme_pkg::PH_ST2: begin
                    n_scl = 1'b0; n_phase = i2cme_pkg::PH_IDLE;
                end
                i2cme_pkg::PH_SP1, i2cme_pkg::PH_FS1: begin
                    n_scl   = 1'b1;
                    n_phase = (r_phase == i2cme_pkg::PH_SP1) ? i2cme_pkg::PH_SP2
                                                              : i2cme_pkg::PH_FS2;
                end
                i2cme_pkg::PH_SP2, i2cme_pkg::PH_FS2: begin
                    n_sda = 1'b1; n_phase = i2cme_pkg::PH_IDLE;
                end
                i2cme_pkg::PH_WR_HI: begin
                    n_scl = 1'b1; n_phase = i2cme_pkg::PH_WR_LO;
                end
                i2cme_pkg::PH_WR_LO: begin
                    n_scl       = 1'b0;
                    n_shift     = w_shift_up;
                    n_bit_count = w_bit_inc;
                    if (w_bit_inc >= i2cme_pkg::BITS_PER_BYTE) begin
                        n_phase = i2cme_pkg::PH_IDLE;
                    end else begin
                        n_sda   = w_shift_up[i2cme_pkg::BYTE_W-1];
                        n_phase = i2cme_pkg::PH_WR_HI;
                    end
                end
                i2cme_pkg::PH_RD_HI: begin
                    n_scl   = 1'b1;
                    n_shift = {r_shift[i2cme_pkg::BYTE_W-2:0], w_sda_in};
                    n_phase = i2cme_pkg::PH_RD_LO;
                end
                i2cme_pkg::PH_RD_LO: begin
                    n_scl       = 1'b0;
                    n_bit_count = w_bit_inc;
                    if (w_bit_inc >= i2cme_pkg::BITS_PER_BYTE) begin
                        n_sda_en = 1'b1;
                        n_sda    = !r_ack_choice;
                        n_phase  = i2cme_pkg::PH_AK_HI;
                    end else begin
                        n_phase  = i2cme_pkg::PH_RD_HI;
                    end
                end
                i2cme_pkg::PH_AK_HI: begin
                    n_scl = 1'b1; n_phase = i2cme_pkg::PH_AK_LO;
                end
                i2cme_pkg::PH_AK_LO: begin
                    n_scl = 1'b0; n_phase = i2cme_pkg::PH_IDLE;
                end
                i2cme_pkg::PH_WA_HI: begin
                    n_scl = 1'b1; n_phase = i2cme_pkg::PH_WA_POLL;
                end
                i2cme_pkg::PH_WA_POLL: begin
                    if (!w_sda_in) begin
                        n_scl   = 1'b0;
                        n_phase = i2cme_pkg::PH_IDLE;
                    end else if (r_poll >= r_ack_timeout) begin
                        // timed out: pull both lines low and run a stop
                        n_sda_en = 1'b1; n_scl = 1'b0; n_sda = 1'b0;
                        n_phase  = i2cme_pkg::PH_FS1;
                    end else begin
                        n_poll = r_poll + 8'd1;
                    end
                end
                default: begin
                    n_phase = i2cme_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // result
    always_comb begin
        n_res           = '0;
        n_res.scl       = n_scl;
        n_res.sda_out   = n_sda;
        n_res.sda_drive = n_sda_en;
        n_res.busy_res  = (n_phase != i2cme_pkg::PH_IDLE);
        if (w_kind != i2cme_pkg::KIND_TICK) begin
            n_res.rejected = !w_idle;
        end else begin
            unique case (r_phase)
                i2cme_pkg::PH_ST2, i2cme_pkg::PH_SP2: begin
                    n_res.done_res = 1'b1;
                end
                i2cme_pkg::PH_FS2: begin
                    n_res.done_res   = 1'b1;
                    n_res.ack_failed = 1'b1;
                end
                i2cme_pkg::PH_WR_LO: begin
                    n_res.done_res = (w_bit_inc >= i2cme_pkg::BITS_PER_BYTE);
                end
                i2cme_pkg::PH_AK_LO: begin
                    n_res.done_res = 1'b1;
                    if (r_bit_count == i2cme_pkg::BITS_PER_BYTE) begin
                        n_res.read_data = r_shift;
                    end
                end
                i2cme_pkg::PH_WA_POLL: begin
                    n_res.done_res = !w_sda_in;
                end
                default: begin
                    n_res.done_res = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= i2cme_pkg::PH_IDLE;
            r_bit_count   <= '0;
            r_shift       <= '0;
            r_poll        <= '0;
            r_scl         <= 1'b1;
            r_sda         <= 1'b1;
            r_sda_en      <= 1'b1;
            r_ack_choice  <= 1'b0;
            r_ack_timeout <= i2cme_pkg::ACK_TIMEOUT_RST;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_ack_timeout <= i_cfg_data;
            end
            if (w_accept) begin
                r_phase      <= n_phase;
                r_bit_count  <= n_bit_count;
                r_shift      <= n_shift;
                r_poll       <= n_poll;
                r_scl        <= n_scl;
                r_sda        <= n_sda;
                r_sda_en     <= n_sda_en;
                r_ack_choice <= n_ack_choice;
                r_out_valid  <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // result payload, held while the item waits
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res <= n_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_res};

    a_accept_gives_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out_valid)
        else $error("accepted item produced no result");

    a_fail_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.ack_failed |-> r_res.done_res && !r_res.busy_res)
        else $error("ack failure reported without a finished sequence");

    a_done_not_rejected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_res.done_res && r_res.rejected))
        else $error("item both finished a sequence and was rejected");

    a_reject_keeps_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.rejected |-> r_res.busy_res)
        else $error("rejected command while the engine was idle");

endmodule

`default_nettype wire

// ----- verif/i2c_master_bit_engine_test.sv -----
`timescale 1ns / 1ps

module i2c_master_bit_engine_test;

    import i2cme_pkg::*;

    localparam int STALL_CYCLES = 300;
    localparam int SEGMENTS     = 6;
    localparam int RANDOM_ITEMS = 190;
    localparam int MAX_REPORTS  = 50;

    // pin states that can be read off directly
    localparam t_result BUS_FREE = '{scl: 1'b1, sda_out: 1'b1, sda_drive: 1'b1, default: '0};
    localparam t_result START_HELD = '{scl: 1'b1, sda_out: 1'b1, sda_drive: 1'b1,
                                       busy_res: 1'b1, default: '0};
    localparam t_result START_REFUSED = '{scl: 1'b1, sda_out: 1'b1, sda_drive: 1'b1,
                                          busy_res: 1'b1, rejected: 1'b1, default: '0};

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  tx;
        logic        ack;
        logic        sda;
        logic [7:0]  reps;
        logic        fixed;
        t_result     want;
    } t_step_row;

    localparam int DIRECTED_ROWS = 31;
    localparam t_step_row DIRECTED [DIRECTED_ROWS] = '{
        '{KIND_TICK,  8'h00, 1'b0, 1'b0, 8'd1,  1'b1, BUS_FREE},       // tick while idle
        '{KIND_START, 8'h00, 1'b0, 1'b0, 8'd1,  1'b1, START_HELD},
        '{KIND_NACK,  8'h00, 1'b0, 1'b0, 8'd1,  1'b1, START_REFUSED},  // command while busy
        '{KIND_TICK,  8'h00, 1'b0, 1'b1, 8'd2,  1'b0, '0},
        '{KIND_WRITE, 8'hFF, 1'b0, 1'b0, 8'd1,  1'b0, '0},
        '{KIND_TICK,  8'h00, 1'b0, 1'b0, 8'd16, 1'b0, '0},
        '{KIND_WACK,  8'h00, 1'b0, 1'b0, 8'd1,  1'b0, '0},
        '{KIND_TICK,  8'h00, 1'b0, 1'b0, 8'd2,  1'b0, '0},
        '{KIND_WRITE, 8'h00, 1'b1, 1'b1, 8'd1,  1'b0, '0},
        '{KIND_TICK,  8'hFF, 1'b1, 1'b1, 8'd16, 1'b0, '0},
        '{KIND_WACK,  8'h00, 1'b0, 1'b0, 8'd1,  1'b0, '0},
        '{KIND_TICK,  8'h00, 1'b0, 1'b1, 8'd1,  1'b0, '0},
        '{KIND_WRITE, 8'hA5, 1'b1, 1'b0, 8'd1,  1'b0, '0},
        '{KIND_TICK,  8'h00, 1'b0, 1'b1, 8'd3,  1'b0, '0},
        '{KIND_TICK,  8'h00, 1'b0, 1'b0, 8'd1,  1'b0, '0},
        '{KIND_READ,  8'h00, 1'b1, 1'b0, 8'd1,  1'b0, '0},
        '{KIND_TICK,  8'h00, 1'b0, 1'b1, 8'd18, 1'b0, '0},
        '{KIND_READ,  8'hFF, 1'b0, 1'b1, 8'd1,  1'b0, '0},
        '{KIND_STOP,  8'h00, 1'b1, 1'b0, 8'd1,  1'b0, '0},
        '{KIND_TICK,  8'h00, 1'b0, 1'b0, 8'd18, 1'b0, '0},
        '{KIND_READ,  8'h00, 1'b1, 1'b0, 8'd1,  1'b0, '0},
        '{KIND_TICK,  8'h00, 1'b0, 1'b1, 8'd1,  1'b0, '0},
        '{KIND_TICK,  8'h00, 1'b0, 1'b0, 8'd1,  1'b0, '0},
        '{KIND_TICK,  8'h00, 1'b0, 1'b1, 8'd16, 1'b0, '0},
        '{KIND_ACK,   8'h00, 1'b0, 1'b0, 8'd1,  1'b0, '0},
        '{KIND_TICK,  8'h00, 1'b0, 1'b0, 8'd2,  1'b0, '0},
        '{KIND_NACK,  8'h00, 1'b0, 1'b0, 8'd1,  1'b0, '0},
        '{KIND_TICK,  8'h00, 1'b0, 1'b0, 8'd2,  1'b0, '0},
        '{KIND_STOP,  8'h00, 1'b0, 1'b0, 8'd1,  1'b0, '0},
        '{KIND_START, 8'h00, 1'b0, 1'b0, 8'd1,  1'b0, '0},
        '{KIND_TICK,  8'h00, 1'b0, 1'b0, 8'd2,  1'b0, '0}
    };

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [S_TDATA_W-1:0]    s_axis_tdata = '0;
    logic [S_TUSER_W-1:0]    s_axis_tuser = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]    m_axis_tdata;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [BYTE_W-1:0]       i_cfg_data = '0;

    // predicted engine state
    t_phase                  eng_phase = PH_IDLE;
    logic [BITCNT_W-1:0]     eng_bits = '0;
    logic [BYTE_W-1:0]       eng_shift = '0;
    logic [BYTE_W-1:0]       eng_polls = '0;
    logic                    eng_scl = 1'b1;
    logic                    eng_sda = 1'b1;
    logic                    eng_drive = 1'b1;
    logic                    eng_ack_sel = 1'b0;
    logic [BYTE_W-1:0]       timeout_reg = ACK_TIMEOUT_RST;

    t_result                 pending_pins[$];

    int                      send_idle_pct = 0;
    int                      recv_idle_pct = 0;
    int                      stall_orders = 0;
    int                      stall_taken = 0;
    int                      hold_left = 0;
    int                      items_sent = 0;
    int                      results_seen = 0;
    int                      done_seen = 0;
    int                      fails_seen = 0;
    int                      rejects_seen = 0;
    int                      mismatches = 0;

    i2c_master_bit_engine DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Advance the predicted engine by one item and return the pins it leaves.
    function automatic t_result next_pin_state(input t_kind kind, input logic [7:0] tx,
                                               input logic ack_in, input logic sda_in);
        t_result r;
        r = '0;
        if (kind != KIND_TICK) begin
            if (eng_phase != PH_IDLE) begin
                r.rejected = 1'b1;
            end else begin
                case (kind)
                    KIND_START: begin
                        eng_drive = 1'b1; eng_sda = 1'b1; eng_scl = 1'b1;
                        eng_phase = PH_ST1;
                    end
                    KIND_STOP: begin
                        eng_drive = 1'b1; eng_scl = 1'b0; eng_sda = 1'b0;
                        eng_phase = PH_SP1;
                    end
                    KIND_WRITE: begin
                        eng_drive = 1'b1; eng_scl = 1'b0;
                        eng_shift = tx; eng_bits = '0; eng_sda = tx[7];
                        eng_phase = PH_WR_HI;
                    end
                    KIND_READ: begin
                        eng_drive = 1'b0; eng_sda = 1'b1; eng_scl = 1'b0;
                        eng_shift = '0; eng_bits = '0; eng_ack_sel = ack_in;
                        eng_phase = PH_RD_HI;
                    end
                    KIND_WACK: begin
                        eng_drive = 1'b0; eng_sda = 1'b1; eng_scl = 1'b0;
                        eng_polls = '0; eng_phase = PH_WA_HI;
                    end
                    default: begin
                        eng_drive = 1'b1; eng_scl = 1'b0;
                        eng_sda = (kind == KIND_NACK);
                        eng_bits = '0; eng_phase = PH_AK_HI;
                    end
                endcase
            end
        end else begin
            case (eng_phase)
                PH_ST1: begin eng_sda = 1'b0; eng_phase = PH_ST2; end
                PH_ST2: begin eng_scl = 1'b0; eng_phase = PH_IDLE; r.done_res = 1'b1; end
                PH_SP1: begin eng_scl = 1'b1; eng_phase = PH_SP2; end
                PH_SP2: begin eng_sda = 1'b1; eng_phase = PH_IDLE; r.done_res = 1'b1; end
                PH_FS1: begin eng_scl = 1'b1; eng_phase = PH_FS2; end
                PH_FS2: begin
                    eng_sda = 1'b1; eng_phase = PH_IDLE;
                    r.done_res = 1'b1; r.ack_failed = 1'b1;
                end
                PH_WR_HI: begin eng_scl = 1'b1; eng_phase = PH_WR_LO; end
                PH_WR_LO: begin
                    eng_scl = 1'b0;
                    eng_shift = eng_shift << 1;
                    eng_bits = eng_bits + 1'b1;
                    if (eng_bits >= BITS_PER_BYTE) begin
                        eng_phase = PH_IDLE; r.done_res = 1'b1;
                    end else begin
                        eng_sda = eng_shift[7];
                        eng_phase = PH_WR_HI;
                    end
                end
                PH_RD_HI: begin
                    eng_scl = 1'b1;
                    eng_shift = {eng_shift[6:0], sda_in};
                    eng_phase = PH_RD_LO;
                end
                PH_RD_LO: begin
                    eng_scl = 1'b0;
                    eng_bits = eng_bits + 1'b1;
                    if (eng_bits >= BITS_PER_BYTE) begin
                        eng_drive = 1'b1;
                        eng_sda = ~eng_ack_sel;
                        eng_phase = PH_AK_HI;
                    end else begin
                        eng_phase = PH_RD_HI;
                    end
                end
                PH_AK_HI: begin eng_scl = 1'b1; eng_phase = PH_AK_LO; end
                PH_AK_LO: begin
                    eng_scl = 1'b0; eng_phase = PH_IDLE; r.done_res = 1'b1;
                    // only a finished read hands back its byte
                    if (eng_bits == BITS_PER_BYTE)
                        r.read_data = eng_shift;
                end
                PH_WA_HI: begin eng_scl = 1'b1; eng_phase = PH_WA_POLL; end
                PH_WA_POLL: begin
                    if (!sda_in) begin
                        eng_scl = 1'b0; eng_phase = PH_IDLE; r.done_res = 1'b1;
                    end else if (eng_polls >= timeout_reg) begin
                        eng_drive = 1'b1; eng_scl = 1'b0; eng_sda = 1'b0;
                        eng_phase = PH_FS1;
                    end else begin
                        eng_polls = eng_polls + 1'b1;
                    end
                end
                default: ;
            endcase
        end
        r.scl       = eng_scl;
        r.sda_out   = eng_sda;
        r.sda_drive = eng_drive;
        r.busy_res  = (eng_phase != PH_IDLE);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] result %0d: %s is %0h, expected %0h",
                     $time, results_seen, what, got, want);
    endtask

    // Offer one item; on acceptance record its predicted pins. Returns at the accepting edge.
    task automatic send_item(input t_kind kind, input logic [7:0] tx, input logic ack,
                             input logic sda, input logic fixed = 1'b0,
                             input t_result want = '0);
        t_result pins;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, sda, ack, tx};
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        pins = next_pin_state(kind, tx, ack, sda);
        pending_pins.push_back(fixed ? want : pins);
        items_sent++;
    endtask

    task automatic send_noise();
        send_item(t_kind'($urandom_range(7)), 8'($urandom_range(255)),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    // One command followed by ticks until the engine is idle, with refused commands mixed in.
    task automatic run_transfer();
        int low_pct;
        low_pct = ($urandom_range(99) < 5) ? 0 : $urandom_range(20, 80);
        send_item(t_kind'($urandom_range(1, 7)), 8'($urandom_range(255)),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
        while (eng_phase != PH_IDLE) begin
            if ($urandom_range(99) < 8)
                send_item(t_kind'($urandom_range(1, 7)), 8'($urandom_range(255)),
                          1'($urandom_range(1)), 1'($urandom_range(1)));
            else
                send_item(KIND_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)),
                          ($urandom_range(99) >= low_pct));
        end
    endtask

    // Hold SDA high through a whole wait for ACK so that it times out.
    task automatic run_ack_timeout();
        send_item(KIND_WACK, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
        while (eng_phase != PH_IDLE)
            send_item(KIND_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
    endtask

    // Bring the engine to idle, then hold off until every result is back.
    task automatic drain_engine();
        while (eng_phase != PH_IDLE)
            send_item(KIND_TICK, 8'h00, 1'b0, 1'b0);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_pins.size() != 0)
            @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_timeout(input logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        timeout_reg = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // receiver: random back-pressure, plus long hold-offs on request
    always @(negedge i_clk) begin
        if (stall_taken != stall_orders) begin
            stall_taken   <= stall_orders;
            hold_left     <= STALL_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[14:0]);
            if (pending_pins.size() == 0) begin
                report_mismatch("unexpected result, tdata", m_axis_tdata, 0);
            end else begin
                want = pending_pins.pop_front();
                if (got.scl !== want.scl)
                    report_mismatch("scl", got.scl, want.scl);
                if (got.sda_out !== want.sda_out)
                    report_mismatch("sda_out", got.sda_out, want.sda_out);
                if (got.sda_drive !== want.sda_drive)
                    report_mismatch("sda_drive", got.sda_drive, want.sda_drive);
                if (got.busy_res !== want.busy_res)
                    report_mismatch("busy", got.busy_res, want.busy_res);
                if (got.done_res !== want.done_res)
                    report_mismatch("done", got.done_res, want.done_res);
                if (got.ack_failed !== want.ack_failed)
                    report_mismatch("ack_failed", got.ack_failed, want.ack_failed);
                if (got.read_data !== want.read_data)
                    report_mismatch("read_data", got.read_data, want.read_data);
                if (got.rejected !== want.rejected)
                    report_mismatch("rejected", got.rejected, want.rejected);
                if (m_axis_tdata[15] !== 1'b0)
                    report_mismatch("pad bit", m_axis_tdata[15], 0);
                done_seen    += want.done_res;
                fails_seen   += want.ack_failed;
                rejects_seen += want.rejected;
            end
            results_seen++;
        end
    end

    initial begin
        #2_000_000;
        $display("Run timed out with %0d results outstanding", pending_pins.size());
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int target;
        int mode;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            mode = seg / 2;
            send_idle_pct = (mode == 0) ? 37 : (mode == 1) ? 80 : 0;
            recv_idle_pct <= (mode == 0) ? 80 : (mode == 1) ? 37 : 0;
            case (seg)
                1: write_timeout(8'd0);
                2: write_timeout(8'd255);
                3: write_timeout(8'($urandom_range(2, 254)));
                4: write_timeout(8'd1);
                5: write_timeout(8'($urandom_range(2, 40)));
                default: ;
            endcase

            if (seg == 0) begin
                foreach (DIRECTED[i])
                    repeat (DIRECTED[i].reps)
                        send_item(DIRECTED[i].kind, DIRECTED[i].tx, DIRECTED[i].ack,
                                  DIRECTED[i].sda, DIRECTED[i].fixed, DIRECTED[i].want);
            end
            run_ack_timeout();

            // long receiver hold-off while the sender keeps offering
            if (seg == 0 || seg == 4)
                stall_orders <= stall_orders + 1;

            target = items_sent + RANDOM_ITEMS;
            while (items_sent < target) begin
                if ($urandom_range(99) < 10)
                    repeat ($urandom_range(1, 4)) send_noise();
                else
                    run_transfer();
            end
            drain_engine();
        end

        repeat (10) @(posedge i_clk);
        $display("Sent %0d items over %0d timeout settings; %0d results checked",
                 items_sent, SEGMENTS, results_seen);
        $display("Sequences finished: %0d, ack timeouts: %0d, refused commands: %0d",
                 done_seen, fails_seen, rejects_seen);
        if (mismatches == 0 && pending_pins.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
